### src/scrsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scrsw_pkg;

   localparam int STAMP_W    = 32;
   localparam int SOURCE_W   = 2;
   localparam int SPEAKER_W  = 5;
   localparam int FIELD_W    = 32;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 4 * FIELD_W;

   typedef enum logic [SOURCE_W-1:0] {
      SRC_WINDOW = 2'd0,
      SRC_REF    = 2'd1,
      SRC_HYP    = 2'd2,
      SRC_SPARE  = 2'd3
   } source_type;

   typedef struct packed {
      logic [STAMP_W-1:0]   stamp;
      source_type           source;
      logic                 is_start;
      logic [SPEAKER_W-1:0] speaker;
   } token_type;

endpackage

`default_nettype wire

### src/scoring_region_sweep.sv
`timescale 1ns / 1ps
`default_nettype none

// Sweep over time-sorted segment boundary tokens (ends before starts at equal times). Each
// token passes an input register and then compares its time with the stored
// time of the previous token, updates the window flag or one speaker bit, and, when inside
// the scoring window and strictly later, loads one region (previous time, this time and the
// reference and hypothesis speaker masks as they were before the token) into the output
// register. One token is accepted every cycle while the output side keeps up; the region is
// loaded into the output register as the token leaves the input register, and a stalled
// output keeps the token waiting there. Speaker indices at or above MAX_SPEAKERS
// leave the masks unchanged, and times are truncated to TIME_BITS.
module scoring_region_sweep
   import scrsw_pkg::*;
#(
   parameter int MAX_SPEAKERS = 32,
   parameter int TIME_BITS    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Bits from the lowest up: stamp[31:0], speaker[36:32], zero padding [39:37].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Bits from the lowest up: source[1:0], is_start[2].
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits from the lowest up: region_begin[31:0], region_finish[63:32],
   // ref_speakers[95:64], hyp_speakers[127:96].
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int TIME_W = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
   localparam int MASK_W = (MAX_SPEAKERS < FIELD_W) ? MAX_SPEAKERS : FIELD_W;

   logic                  tok_valid_ff, tok_valid_in;
   token_type             tok_ff, tok_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   logic                  in_window_ff, in_window_in;
   logic [MASK_W-1:0]     ref_active_ff, ref_active_in;
   logic [MASK_W-1:0]     hyp_active_ff, hyp_active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  advance;
   logic                  process;
   logic                  emit;
   logic [TIME_W-1:0]     tok_time;
   logic [FIELD_W-1:0]    spk_onehot;
   logic [MASK_W-1:0]     spk_bit;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !tok_valid_ff || advance;
   assign process    = tok_valid_ff && advance;

   always_comb begin
      tok_in.stamp    = req_tdata[STAMP_W-1:0];
      tok_in.speaker  = req_tdata[STAMP_W +: SPEAKER_W];
      tok_in.source   = source_type'(req_tuser[SOURCE_W-1:0]);
      tok_in.is_start = req_tuser[SOURCE_W];
      tok_valid_in    = req_tready ? req_tvalid : tok_valid_ff;
   end

   assign tok_time   = tok_ff.stamp[TIME_W-1:0];
   assign emit       = in_window_ff && (tok_time > last_time_ff);
   assign spk_onehot = FIELD_W'(1) << tok_ff.speaker;
   assign spk_bit    = spk_onehot[MASK_W-1:0];

   always_comb begin
      last_time_in  = last_time_ff;
      in_window_in  = in_window_ff;
      ref_active_in = ref_active_ff;
      hyp_active_in = hyp_active_ff;
      if (process) begin
         last_time_in = tok_time;
         case (tok_ff.source)
            SRC_WINDOW: in_window_in = tok_ff.is_start;
            SRC_REF: begin
               ref_active_in = tok_ff.is_start ? (ref_active_ff | spk_bit)
                                               : (ref_active_ff & ~spk_bit);
            end
            SRC_HYP: begin
               hyp_active_in = tok_ff.is_start ? (hyp_active_ff | spk_bit)
                                               : (hyp_active_ff & ~spk_bit);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = process && emit;
         rsp_data_in  = {FIELD_W'(hyp_active_ff), FIELD_W'(ref_active_ff),
                         FIELD_W'(tok_time), FIELD_W'(last_time_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff  <= 1'b0;
         last_time_ff  <= '0;
         in_window_ff  <= 1'b0;
         ref_active_ff <= '0;
         hyp_active_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tok_valid_ff  <= tok_valid_in;
         last_time_ff  <= last_time_in;
         in_window_ff  <= in_window_in;
         ref_active_ff <= ref_active_in;
         hyp_active_ff <= hyp_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         tok_ff <= tok_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_region_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[2*FIELD_W-1:FIELD_W] > rsp_data_ff[FIELD_W-1:0]))
      else $error("Region end is not later than its start.");

   a_outside_silent: assert property (@(posedge clock) disable iff (reset)
      (process && !in_window_ff) |=> !rsp_valid_ff)
      else $error("Region produced outside the scoring window.");

   a_time_stored: assert property (@(posedge clock) disable iff (reset)
      process |=> (last_time_ff == $past(tok_time)))
      else $error("Token time was not stored.");

   a_window_follows: assert property (@(posedge clock) disable iff (reset)
      (process && tok_ff.source == SRC_WINDOW) |=> (in_window_ff == $past(tok_ff.is_start)))
      else $error("Window flag does not follow the window token.");
`endif

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import scrsw_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_LEN = 100;

   typedef struct packed {
      logic [FIELD_W-1:0] hyp_mask;
      logic [FIELD_W-1:0] ref_mask;
      logic [FIELD_W-1:0] end_tick;
      logic [FIELD_W-1:0] start_tick;
   } region_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   token_type  tokens_pending[$];
   region_type regions_due[$];

   logic [STAMP_W-1:0] last_stamp;
   logic               in_window;
   logic [FIELD_W-1:0] ref_active;
   logic [FIELD_W-1:0] hyp_active;

   int  tokens_accepted;
   int  token_total;
   int  mismatches;
   int  idle_cycles;
   int  phase;
   logic req_taken;

   scoring_region_sweep dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic token_type make_token(input logic [STAMP_W-1:0] stamp,
                                            input source_type source,
                                            input logic is_start,
                                            input logic [SPEAKER_W-1:0] speaker);
      token_type tok;
      tok.stamp    = stamp;
      tok.source   = source;
      tok.is_start = is_start;
      tok.speaker  = speaker;
      return tok;
   endfunction

   task automatic queue_token(input token_type tok);
      tokens_pending.insert(tokens_pending.size(), tok);
   endtask

   function automatic source_type random_source();
      int pick;
      pick = $urandom_range(99);
      if (pick < 46) begin
         return SRC_REF;
      end else if (pick < 92) begin
         return SRC_HYP;
      end else if (pick < 96) begin
         return SRC_WINDOW;
      end else begin
         return SRC_SPARE;
      end
   endfunction

   task automatic add_session();
      logic [STAMP_W-1:0] stamp;
      int                 count;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         stamp = $urandom;
      end else if (pick < 85) begin
         stamp = $urandom_range(0, 1000);
      end else begin
         stamp = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      queue_token(make_token(stamp, SRC_WINDOW, 1'b1, 5'd0));
      count = $urandom_range(2, 24);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            stamp = stamp;
         end else if (pick < 95) begin
            stamp = stamp + $urandom_range(1, 1000);
         end else begin
            stamp = stamp + $urandom;
         end
         queue_token(make_token(stamp, random_source(), 1'($urandom_range(1)),
                                SPEAKER_W'($urandom_range(31))));
      end
      stamp = stamp + $urandom_range(0, 50);
      queue_token(make_token(stamp, SRC_WINDOW, 1'b0, SPEAKER_W'($urandom_range(31))));
   endtask

   task automatic sweep_token(input token_type tok);
      region_type region;
      if (in_window && tok.stamp > last_stamp) begin
         region.start_tick = last_stamp;
         region.end_tick   = tok.stamp;
         region.ref_mask   = ref_active;
         region.hyp_mask   = hyp_active;
         regions_due.insert(regions_due.size(), region);
      end
      case (tok.source)
         SRC_REF:    ref_active[tok.speaker] = tok.is_start;
         SRC_HYP:    hyp_active[tok.speaker] = tok.is_start;
         SRC_WINDOW: in_window = tok.is_start;
         default:    ;
      endcase
      last_stamp = tok.stamp;
   endtask

   // The driver moves to a new transfer only once the current one has been taken.
   always @(negedge clock) begin
      token_type tok;
      int        idle_pct;
      int        stall_pct;
      idle_pct  = (phase == 1) ? 70 : ((phase == 3) ? 36 : 0);
      stall_pct = (phase == 2) ? 70 : ((phase == 3) ? 36 : 0);
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || req_taken) begin
            if (tokens_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
               tok = tokens_pending.pop_front();
               req_tdata  <= {3'b000, tok.speaker, tok.stamp};
               req_tuser  <= {tok.is_start, tok.source};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      region_type seen;
      region_type wanted;
      token_type  tok;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (regions_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected region: begin %h finish %h ref %h hyp %h",
                           seen.start_tick, seen.end_tick, seen.ref_mask, seen.hyp_mask);
               end
            end else begin
               wanted = regions_due.pop_front();
               if (seen !== wanted) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("region mismatch: expected begin %h finish %h ref %h hyp %h",
                              wanted.start_tick, wanted.end_tick, wanted.ref_mask,
                              wanted.hyp_mask);
                     $display("                 actual   begin %h finish %h ref %h hyp %h",
                              seen.start_tick, seen.end_tick, seen.ref_mask, seen.hyp_mask);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            tok.stamp    = req_tdata[STAMP_W-1:0];
            tok.speaker  = req_tdata[STAMP_W +: SPEAKER_W];
            tok.source   = source_type'(req_tuser[SOURCE_W-1:0]);
            tok.is_start = req_tuser[SOURCE_W];
            sweep_token(tok);
            tokens_accepted++;
            phase <= ((tokens_accepted / PHASE_LEN) % 4);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      rsp_tready      = 1'b0;
      req_taken       = 1'b0;
      last_stamp      = '0;
      in_window       = 1'b0;
      ref_active      = '0;
      hyp_active      = '0;
      tokens_accepted = 0;
      mismatches      = 0;
      idle_cycles     = 0;
      phase           = 0;

      // The opening tokens cover the first token after reset, equal and earlier times,
      // the spare source, repeated starts and ends, and the extremes of time and speaker.
      queue_token(make_token(32'd0, SRC_REF, 1'b1, 5'd0));
      queue_token(make_token(32'd0, SRC_WINDOW, 1'b1, 5'd31));
      queue_token(make_token(32'd0, SRC_HYP, 1'b1, 5'd31));
      queue_token(make_token(32'd10, SRC_REF, 1'b1, 5'd31));
      queue_token(make_token(32'd10, SRC_REF, 1'b1, 5'd31));
      queue_token(make_token(32'd20, SRC_HYP, 1'b0, 5'd5));
      queue_token(make_token(32'd30, SRC_SPARE, 1'b1, 5'd7));
      queue_token(make_token(32'd40, SRC_WINDOW, 1'b1, 5'd0));
      queue_token(make_token(32'd35, SRC_REF, 1'b0, 5'd0));
      queue_token(make_token(32'd50, SRC_WINDOW, 1'b0, 5'd0));
      queue_token(make_token(32'd60, SRC_WINDOW, 1'b0, 5'd0));
      queue_token(make_token(32'd70, SRC_HYP, 1'b1, 5'd16));
      queue_token(make_token(32'hFFFF_FFF0, SRC_WINDOW, 1'b1, 5'd0));
      queue_token(make_token(32'hFFFF_FFFF, SRC_REF, 1'b1, 5'd15));
      queue_token(make_token(32'hFFFF_FFFF, SRC_HYP, 1'b0, 5'd31));
      queue_token(make_token(32'hFFFF_FFFF, SRC_SPARE, 1'b0, 5'd10));
      queue_token(make_token(32'd5, SRC_REF, 1'b1, 5'd21));
      queue_token(make_token(32'd5, SRC_WINDOW, 1'b0, 5'd0));

      while (tokens_pending.size() < 1900) begin
         if ($urandom_range(99) < 10) begin
            queue_token(make_token($urandom,
                                   source_type'(SOURCE_W'($urandom_range(3))),
                                   1'($urandom_range(1)),
                                   SPEAKER_W'($urandom_range(31))));
         end else begin
            add_session();
         end
      end
      token_total = tokens_pending.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (tokens_accepted < token_total || regions_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && regions_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
